// ===== hw/rtl/gic_pkg.sv =====
// Shared types, register map and opcodes of the GPIO interrupt controller.
`default_nettype none

package gic_pkg;

   localparam int unsigned DATA_W            = 16;
   localparam int unsigned ADDR_W            = 6;
   localparam int unsigned OPCODE_W          = 2;
   localparam int unsigned PIN_IDX_W         = 4;
   localparam int unsigned PIN_COUNT_DEFAULT = 16;

   localparam logic [OPCODE_W-1:0] OP_READ  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_WRITE = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_PIN   = 2'd2;

   localparam logic [ADDR_W-1:0] ADDR_DIR    = 6'd0;
   localparam logic [ADDR_W-1:0] ADDR_INDATA = 6'd1;
   localparam logic [ADDR_W-1:0] ADDR_SET    = 6'd2;
   localparam logic [ADDR_W-1:0] ADDR_CLR    = 6'd3;
   localparam logic [ADDR_W-1:0] ADDR_LVLSEL = 6'd4;
   localparam logic [ADDR_W-1:0] ADDR_RISE   = 6'd5;
   localparam logic [ADDR_W-1:0] ADDR_FALL   = 6'd6;
   localparam logic [ADDR_W-1:0] ADDR_IRQEN  = 6'd7;
   localparam logic [ADDR_W-1:0] ADDR_STATUS = 6'd8;
   localparam logic [ADDR_W-1:0] ADDR_STCLR  = 6'd9;
   localparam logic [ADDR_W-1:0] ADDR_INEN   = 6'd10;

   typedef struct packed {
      logic [OPCODE_W-1:0]  opcode;
      logic [ADDR_W-1:0]    word_address;
      logic [DATA_W-1:0]    write_data;
      logic [PIN_IDX_W-1:0] pin_index;
      logic                 pin_level;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic [DATA_W-1:0] pin_outputs;
      logic [DATA_W-1:0] irq_lines;
   } rsp_type;

endpackage

`default_nettype wire

// ===== hw/rtl/gic_regs.sv =====
// Register file of the GPIO controller with bus decode, edge latching and result logic.
`default_nettype none

module gic_regs #(
   parameter int unsigned PIN_COUNT = gic_pkg::PIN_COUNT_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_en,
   input  gic_pkg::req_type  item,
   output gic_pkg::rsp_type  result
);
   import gic_pkg::*;

   localparam int unsigned W = (PIN_COUNT < DATA_W) ? PIN_COUNT : DATA_W;

   logic [W-1:0] direction_ff,    direction_in;
   logic [W-1:0] output_data_ff,  output_data_in;
   logic [W-1:0] level_select_ff, level_select_in;
   logic [W-1:0] rise_enable_ff,  rise_enable_in;
   logic [W-1:0] fall_enable_ff,  fall_enable_in;
   logic [W-1:0] irq_enable_ff,   irq_enable_in;
   logic [W-1:0] input_enable_ff, input_enable_in;
   logic [W-1:0] pin_levels_ff,   pin_levels_in;
   logic [W-1:0] edge_status_ff,  edge_status_in;

   logic [W-1:0] wdata;
   logic [W-1:0] live;
   logic [W-1:0] pin_bit;
   logic [W-1:0] read_value;
   logic         pin_ok;

   always_comb begin
      direction_in    = direction_ff;
      output_data_in  = output_data_ff;
      level_select_in = level_select_ff;
      rise_enable_in  = rise_enable_ff;
      fall_enable_in  = fall_enable_ff;
      irq_enable_in   = irq_enable_ff;
      input_enable_in = input_enable_ff;
      pin_levels_in   = pin_levels_ff;
      edge_status_in  = edge_status_ff;
      read_value      = '0;
      wdata           = item.write_data[W-1:0];
      live            = ~direction_ff & input_enable_ff;
      pin_bit         = W'(1) << item.pin_index;
      pin_ok          = PIN_COUNT > 32'(item.pin_index);

      case (item.opcode)
         OP_READ: begin
            case (item.word_address)
               ADDR_DIR:    read_value = direction_ff;
               ADDR_INDATA: read_value = live & pin_levels_ff;
               ADDR_LVLSEL: read_value = level_select_ff;
               ADDR_RISE:   read_value = rise_enable_ff;
               ADDR_FALL:   read_value = fall_enable_ff;
               ADDR_IRQEN:  read_value = irq_enable_ff;
               ADDR_STATUS: read_value = edge_status_ff
                                       | (live & level_select_ff & pin_levels_ff);
               ADDR_INEN:   read_value = input_enable_ff;
               default:     read_value = '0;
            endcase
         end
         OP_WRITE: begin
            case (item.word_address)
               ADDR_DIR:    direction_in    = wdata;
               ADDR_SET:    output_data_in  = output_data_ff | wdata;
               ADDR_CLR:    output_data_in  = output_data_ff & ~wdata;
               ADDR_LVLSEL: level_select_in = wdata;
               ADDR_RISE:   rise_enable_in  = rise_enable_ff | wdata;
               ADDR_FALL:   fall_enable_in  = fall_enable_ff | wdata;
               ADDR_IRQEN:  irq_enable_in   = wdata;
               ADDR_STCLR:  edge_status_in  = edge_status_ff & ~wdata;
               ADDR_INEN:   input_enable_in = wdata;
               default:     ;
            endcase
         end
         OP_PIN: begin
            if (pin_ok) begin
               if (item.pin_level) begin
                  if (|(live & rise_enable_ff & ~pin_levels_ff & pin_bit)) begin
                     edge_status_in = edge_status_ff | pin_bit;
                  end
                  pin_levels_in = pin_levels_ff | pin_bit;
               end else begin
                  if (|(live & fall_enable_ff & pin_levels_ff & pin_bit)) begin
                     edge_status_in = edge_status_ff | pin_bit;
                  end
                  pin_levels_in = pin_levels_ff & ~pin_bit;
               end
            end
         end
         default: ;
      endcase

      result.read_data   = DATA_W'(read_value);
      result.pin_outputs = DATA_W'(direction_in & output_data_in);
      result.irq_lines   = DATA_W'(irq_enable_in & (edge_status_in
                           | (~direction_in & input_enable_in & level_select_in
                              & pin_levels_in)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff    <= '0;
         output_data_ff  <= '0;
         level_select_ff <= '0;
         rise_enable_ff  <= '0;
         fall_enable_ff  <= '0;
         irq_enable_ff   <= '0;
         input_enable_ff <= '0;
         pin_levels_ff   <= '0;
         edge_status_ff  <= '0;
      end else if (step_en) begin
         direction_ff    <= direction_in;
         output_data_ff  <= output_data_in;
         level_select_ff <= level_select_in;
         rise_enable_ff  <= rise_enable_in;
         fall_enable_ff  <= fall_enable_in;
         irq_enable_ff   <= irq_enable_in;
         input_enable_ff <= input_enable_in;
         pin_levels_ff   <= pin_levels_in;
         edge_status_ff  <= edge_status_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/gpio_interrupt_controller.sv =====
// Top level of the GPIO interrupt controller: input register, register file and result register.
//
//   Channel   Direction   Payload               Handshake
//   req_      in          gic_pkg::req_type     req_valid / req_stall
//   rsp_      out         gic_pkg::rsp_type     rsp_valid / rsp_stall
//
// Each transaction is held in the input register and is then processed
// into the result register.
// One transaction is accepted per cycle while the result register is free or drained.
// Reset clears the GPIO registers and both valid flags.
// A stall on the result side holds the result register and then the input register.
`default_nettype none

module gpio_interrupt_controller #(
   parameter int unsigned PIN_COUNT = gic_pkg::PIN_COUNT_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  gic_pkg::req_type  req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output gic_pkg::rsp_type  rsp_payload
);
   import gic_pkg::*;

   logic    in_valid_ff,  in_valid_in;
   req_type in_item_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_item_ff;
   rsp_type result;
   logic    advance;
   logic    accept;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   gic_regs #(
      .PIN_COUNT (PIN_COUNT)
   ) u_regs (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (in_item_ff),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff <= req_payload;
      end
      if (advance) begin
         out_item_ff <= result;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_item_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/gic_checker.sv =====
// Port-level assertions for the GPIO interrupt controller and their bind.
`default_nettype none

module gic_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input gic_pkg::req_type  req_payload,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input gic_pkg::rsp_type  rsp_payload
);
   import gic_pkg::*;

   logic req_accept;

   assign req_accept = req_valid && !req_stall;

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_payload))
      else $error("request transaction changed while stalled");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result transaction changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a stalled result");

   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_accept, 2))
      else $error("result transaction without an accepted request");

endmodule

bind gpio_interrupt_controller gic_checker u_gic_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

`default_nettype wire

// ===== tb/sv/gpio_interrupt_controller_tb.sv =====
// Self-checking testbench for the GPIO interrupt controller, with directed vectors and random traffic.
`timescale 1ns / 100ps

module gpio_interrupt_controller_tb;
   import gic_pkg::*;

   localparam logic [OPCODE_W-1:0] OP_UNUSED   = 2'd3;
   localparam logic [ADDR_W-1:0]   ADDR_SPARE  = 6'd11;
   localparam logic [ADDR_W-1:0]   ADDR_TOP    = 6'd63;
   localparam logic [DATA_W-1:0]   PIN_MASK    = DATA_W'((64'd1 << PIN_COUNT_DEFAULT) - 1);
   localparam int unsigned         CYCLE_LIMIT = 200000;
   localparam int unsigned         PHASE_ITEMS = 360;
   localparam int unsigned         PRINT_LIMIT = 40;

   typedef struct packed {
      req_type item;
      logic    known;
      rsp_type result;
   } vector_type;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_payload;

   logic [DATA_W-1:0] pred_dir    = '0;
   logic [DATA_W-1:0] gpio_out    = '0;
   logic [DATA_W-1:0] gpio_lvlsel = '0;
   logic [DATA_W-1:0] gpio_rise   = '0;
   logic [DATA_W-1:0] gpio_fall   = '0;
   logic [DATA_W-1:0] gpio_irqen  = '0;
   logic [DATA_W-1:0] pred_inen   = '0;
   logic [DATA_W-1:0] gpio_levels = '0;
   logic [DATA_W-1:0] gpio_edges  = '0;

   rsp_type     pending_responses [$];
   vector_type  directed_vectors [$];
   rsp_type     oldest_response;
   int unsigned mismatch_count = 0;
   int unsigned items_sent     = 0;
   int unsigned cycle_count    = 0;
   int unsigned send_idle_pct  = 0;
   int unsigned stall_pct      = 0;

   gpio_interrupt_controller u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic req_type make_req(input logic [OPCODE_W-1:0] op,
                                        input logic [ADDR_W-1:0] addr,
                                        input logic [DATA_W-1:0] data,
                                        input logic [PIN_IDX_W-1:0] idx,
                                        input logic lvl);
      req_type r;
      r.opcode       = op;
      r.word_address = addr;
      r.write_data   = data;
      r.pin_index    = idx;
      r.pin_level    = lvl;
      return r;
   endfunction

   task automatic add_vector(input req_type item, input logic known, input rsp_type result);
      vector_type row;
      row.item   = item;
      row.known  = known;
      row.result = result;
      directed_vectors.push_back(row);
   endtask

   function automatic rsp_type predict_gpio_response(input req_type item);
      rsp_type           r;
      logic [DATA_W-1:0] live;
      logic [DATA_W-1:0] data;
      logic [DATA_W-1:0] pin_bit;
      live    = ~pred_dir & pred_inen & PIN_MASK;
      data    = item.write_data & PIN_MASK;
      pin_bit = DATA_W'(1) << item.pin_index;
      r.read_data = '0;
      case (item.opcode)
         OP_READ: begin
            case (item.word_address)
               ADDR_DIR:    r.read_data = pred_dir;
               ADDR_INDATA: r.read_data = live & gpio_levels;
               ADDR_LVLSEL: r.read_data = gpio_lvlsel;
               ADDR_RISE:   r.read_data = gpio_rise;
               ADDR_FALL:   r.read_data = gpio_fall;
               ADDR_IRQEN:  r.read_data = gpio_irqen;
               ADDR_STATUS: r.read_data = gpio_edges | (live & gpio_lvlsel & gpio_levels);
               ADDR_INEN:   r.read_data = pred_inen;
               default:     r.read_data = '0;
            endcase
         end
         OP_WRITE: begin
            case (item.word_address)
               ADDR_DIR:    pred_dir    = data;
               ADDR_SET:    gpio_out    = gpio_out | data;
               ADDR_CLR:    gpio_out    = gpio_out & ~data & PIN_MASK;
               ADDR_LVLSEL: gpio_lvlsel = data;
               ADDR_RISE:   gpio_rise   = gpio_rise | data;
               ADDR_FALL:   gpio_fall   = gpio_fall | data;
               ADDR_IRQEN:  gpio_irqen  = data;
               ADDR_STCLR:  gpio_edges  = gpio_edges & ~data & PIN_MASK;
               ADDR_INEN:   pred_inen   = data;
               default:     ;
            endcase
         end
         OP_PIN: begin
            if (item.pin_index < PIN_COUNT_DEFAULT) begin
               if (item.pin_level) begin
                  if (|(live & gpio_rise & ~gpio_levels & pin_bit))
                     gpio_edges = gpio_edges | pin_bit;
                  gpio_levels = gpio_levels | pin_bit;
               end else begin
                  if (|(live & gpio_fall & gpio_levels & pin_bit))
                     gpio_edges = gpio_edges | pin_bit;
                  gpio_levels = gpio_levels & ~pin_bit;
               end
               gpio_levels = gpio_levels & PIN_MASK;
            end
         end
         default: ;
      endcase
      live          = ~pred_dir & pred_inen & PIN_MASK;
      r.pin_outputs = pred_dir & gpio_out;
      r.irq_lines   = gpio_irqen & (gpio_edges | (live & gpio_lvlsel & gpio_levels));
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                  input logic [DATA_W-1:0] want);
      if (mismatch_count < PRINT_LIMIT)
         $display("mismatch in %s: got %h, expected %h", what, got, want);
      mismatch_count++;
   endtask

   task automatic drive_transaction(input req_type item, input logic known,
                                    input rsp_type known_rsp);
      rsp_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid   <= 1'b0;
         req_payload <= req_type'($urandom);
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      predicted = predict_gpio_response(item);
      pending_responses.push_back(known ? known_rsp : predicted);
      items_sent++;
      @(negedge clock);
   endtask

   // A well-formed pin sequence: make one pin an input, maybe enable and arm it, toggle it and clear status.
   task automatic run_pin_scenario();
      int unsigned       pin;
      logic [DATA_W-1:0] pin_bit;
      logic              lvl;
      pin     = $urandom_range(15);
      pin_bit = DATA_W'(1) << pin;
      drive_transaction(make_req(OP_WRITE, ADDR_DIR, DATA_W'($urandom) & ~pin_bit, 0, 0),
                        1'b0, '0);
      if ($urandom_range(3) != 0)
         drive_transaction(make_req(OP_WRITE, ADDR_INEN, DATA_W'($urandom) | pin_bit, 0, 0),
                           1'b0, '0);
      if ($urandom_range(1) != 0)
         drive_transaction(make_req(OP_WRITE, ADDR_RISE,
                                    DATA_W'($urandom & $urandom & $urandom) | pin_bit, 0, 0),
                           1'b0, '0);
      if ($urandom_range(1) != 0)
         drive_transaction(make_req(OP_WRITE, ADDR_FALL,
                                    DATA_W'($urandom & $urandom & $urandom) | pin_bit, 0, 0),
                           1'b0, '0);
      if ($urandom_range(2) == 0)
         drive_transaction(make_req(OP_WRITE, ADDR_LVLSEL, DATA_W'($urandom), 0, 0), 1'b0, '0);
      if ($urandom_range(1) != 0)
         drive_transaction(make_req(OP_WRITE, ADDR_IRQEN, DATA_W'($urandom) | pin_bit, 0, 0),
                           1'b0, '0);
      repeat ($urandom_range(2, 6)) begin
         lvl = ($urandom_range(3) == 0) ? 1'($urandom_range(1)) : ~gpio_levels[pin];
         drive_transaction(make_req(OP_PIN, ADDR_W'($urandom), DATA_W'($urandom),
                                    PIN_IDX_W'(pin), lvl), 1'b0, '0);
         if ($urandom_range(2) == 0)
            drive_transaction(make_req(OP_READ, ADDR_STATUS, 0, 0, 0), 1'b0, '0);
      end
      drive_transaction(make_req(OP_READ, ADDR_STATUS, 0, 0, 0), 1'b0, '0);
      drive_transaction(make_req(OP_READ, ADDR_INDATA, 0, 0, 0), 1'b0, '0);
      drive_transaction(make_req(OP_WRITE, ADDR_STCLR,
                                 ($urandom_range(1) != 0) ? pin_bit : DATA_W'($urandom), 0, 0),
                        1'b0, '0);
      drive_transaction(make_req(OP_READ, ADDR_STATUS, 0, 0, 0), 1'b0, '0);
   endtask

   task automatic run_noise_item();
      int unsigned         roll;
      logic [OPCODE_W-1:0] op;
      logic [ADDR_W-1:0]   addr;
      logic [DATA_W-1:0]   data;
      roll = $urandom_range(99);
      if (roll < 30)      op = OP_READ;
      else if (roll < 60) op = OP_WRITE;
      else if (roll < 95) op = OP_PIN;
      else                op = OP_UNUSED;
      addr = ($urandom_range(4) == 0) ? ADDR_W'($urandom_range(63)) : ADDR_W'($urandom_range(10));
      roll = $urandom_range(19);
      if (roll == 0)      data = '1;
      else if (roll == 1) data = '0;
      else                data = DATA_W'($urandom);
      drive_transaction(make_req(op, addr, data, PIN_IDX_W'($urandom), 1'($urandom)), 1'b0, '0);
   endtask

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("== FAIL ==");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_responses.size() == 0) begin
            report_mismatch("unexpected transaction", rsp_payload.read_data, '0);
         end else begin
            oldest_response = pending_responses.pop_front();
            if (rsp_payload.read_data !== oldest_response.read_data)
               report_mismatch("read_data", rsp_payload.read_data, oldest_response.read_data);
            if (rsp_payload.pin_outputs !== oldest_response.pin_outputs)
               report_mismatch("pin_outputs", rsp_payload.pin_outputs,
                               oldest_response.pin_outputs);
            if (rsp_payload.irq_lines !== oldest_response.irq_lines)
               report_mismatch("irq_lines", rsp_payload.irq_lines, oldest_response.irq_lines);
         end
      end
   end

   initial begin
      int unsigned phase;
      int unsigned target;
      vector_type  row;

      // Directed vectors after reset: fixed expectations for extremes and ignored accesses, then predicted ones.
      add_vector(make_req(OP_READ, ADDR_DIR, 0, 0, 0), 1'b1, '{16'h0, 16'h0, 16'h0});
      add_vector(make_req(OP_READ, ADDR_STATUS, 0, 0, 0), 1'b1, '{16'h0, 16'h0, 16'h0});
      add_vector(make_req(OP_READ, ADDR_TOP, '1, '1, 1), 1'b1, '{16'h0, 16'h0, 16'h0});
      add_vector(make_req(OP_WRITE, ADDR_DIR, '1, 0, 0), 1'b1, '{16'h0, 16'h0, 16'h0});
      add_vector(make_req(OP_WRITE, ADDR_SET, '1, 0, 0), 1'b1, '{16'h0, 16'hFFFF, 16'h0});
      add_vector(make_req(OP_WRITE, ADDR_CLR, 16'h00FF, 0, 0), 1'b1, '{16'h0, 16'hFF00, 16'h0});
      add_vector(make_req(OP_WRITE, ADDR_INDATA, '1, 0, 0), 1'b1, '{16'h0, 16'hFF00, 16'h0});
      add_vector(make_req(OP_READ, ADDR_SET, 0, 0, 0), 1'b1, '{16'h0, 16'hFF00, 16'h0});
      add_vector(make_req(OP_UNUSED, ADDR_DIR, '1, '1, 1), 1'b1, '{16'h0, 16'hFF00, 16'h0});
      add_vector(make_req(OP_WRITE, ADDR_SPARE, '1, 0, 0), 1'b0, '0);
      add_vector(make_req(OP_WRITE, ADDR_DIR, 16'h00FF, 0, 0), 1'b0, '0);
      add_vector(make_req(OP_WRITE, ADDR_INEN, '1, 0, 0), 1'b0, '0);
      add_vector(make_req(OP_WRITE, ADDR_IRQEN, '1, 0, 0), 1'b0, '0);
      add_vector(make_req(OP_WRITE, ADDR_RISE, 16'h8000, 0, 0), 1'b0, '0);
      add_vector(make_req(OP_PIN, 0, 0, 4'd15, 1), 1'b0, '0);
      add_vector(make_req(OP_PIN, 0, 0, 4'd0, 1), 1'b0, '0);
      add_vector(make_req(OP_READ, ADDR_INDATA, 0, 0, 0), 1'b0, '0);
      add_vector(make_req(OP_WRITE, ADDR_STCLR, 16'h8000, 0, 0), 1'b0, '0);
      add_vector(make_req(OP_WRITE, ADDR_FALL, 16'h4000, 0, 0), 1'b0, '0);
      add_vector(make_req(OP_PIN, 0, 0, 4'd14, 1), 1'b0, '0);
      add_vector(make_req(OP_PIN, 0, 0, 4'd14, 0), 1'b0, '0);
      add_vector(make_req(OP_WRITE, ADDR_LVLSEL, 16'h2000, 0, 0), 1'b0, '0);
      add_vector(make_req(OP_PIN, 0, 0, 4'd13, 1), 1'b0, '0);
      add_vector(make_req(OP_READ, ADDR_STATUS, 0, 0, 0), 1'b0, '0);
      add_vector(make_req(OP_WRITE, ADDR_STCLR, '1, 0, 0), 1'b0, '0);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 15;
      stall_pct     = 85;
      foreach (directed_vectors[i]) begin
         row = directed_vectors[i];
         drive_transaction(row.item, row.known, row.result);
      end

      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0:       begin send_idle_pct = 15; stall_pct = 85; end
            1:       begin send_idle_pct = 85; stall_pct = 15; end
            default: begin send_idle_pct = 0;  stall_pct = 0;  end
         endcase
         target = items_sent + PHASE_ITEMS;
         while (items_sent < target) begin
            if ($urandom_range(99) < 65) run_pin_scenario();
            else run_noise_item();
         end
      end
      req_valid <= 1'b0;

      while (pending_responses.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (pending_responses.size() != 0)
         report_mismatch("leftover transactions", DATA_W'(pending_responses.size()), '0);

      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/gic_pkg.sv
hw/rtl/gic_regs.sv
hw/rtl/gpio_interrupt_controller.sv
hw/rtl/gic_checker.sv
tb/sv/gpio_interrupt_controller_tb.sv
